// ===== rtl/tiff_ifd_entry_parser_core_defines.svh =====
// Assertion macros used by the directory entry parser core.
`ifndef TIFF_IFD_ENTRY_PARSER_CORE_DEFINES_SVH
`define TIFF_IFD_ENTRY_PARSER_CORE_DEFINES_SVH
`ifndef SYNTHESIS
`define TIFD_ASSERT(name, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define TIFD_ASSERT_ALWAYS(name, prop, msg) \
    name: assert property (@(posedge clk) prop) else $error(msg);
`else
`define TIFD_ASSERT(name, prop, msg)
`define TIFD_ASSERT_ALWAYS(name, prop, msg)
`endif
`endif

// ===== rtl/tifd_pkg.sv =====
// Types, constants and field helpers for the directory entry parser.
package tifd_pkg;

    localparam int MaxEntryBytes      = 20;
    localparam int BigEntryBytes      = 20;
    localparam int StitchedEntryBytes = 16;
    localparam int ClassicEntryBytes  = 12;
    localparam int WideFieldBytes     = 8;
    localparam int NarrowFieldBytes   = 4;
    localparam int BigFieldOffset     = 12;
    localparam int ClassicFieldOffset = 8;
    localparam int OfsW               = 37;

    localparam logic [1:0] MODE_CLASSIC  = 2'd0;
    localparam logic [1:0] MODE_BIGTIFF  = 2'd1;
    localparam logic [1:0] MODE_STITCHED = 2'd2;
    localparam logic [1:0] MODE_EXTENDED = 2'd3;

    localparam logic [3:0] REG_FORMAT_MODE       = 4'd0;
    localparam logic [3:0] REG_BIG_ENDIAN        = 4'd1;
    localparam logic [3:0] REG_TAG_COUNT         = 4'd2;
    localparam logic [3:0] REG_TABLE_FILE_OFFSET = 4'd3;

    localparam logic [15:0] TYPE_BYTE      = 16'd1;
    localparam logic [15:0] TYPE_ASCII     = 16'd2;
    localparam logic [15:0] TYPE_SHORT     = 16'd3;
    localparam logic [15:0] TYPE_LONG      = 16'd4;
    localparam logic [15:0] TYPE_RATIONAL  = 16'd5;
    localparam logic [15:0] TYPE_SBYTE     = 16'd6;
    localparam logic [15:0] TYPE_UNDEFINED = 16'd7;
    localparam logic [15:0] TYPE_SSHORT    = 16'd8;
    localparam logic [15:0] TYPE_SLONG     = 16'd9;
    localparam logic [15:0] TYPE_SRATIONAL = 16'd10;
    localparam logic [15:0] TYPE_FLOAT     = 16'd11;
    localparam logic [15:0] TYPE_DOUBLE    = 16'd12;
    localparam logic [15:0] TYPE_IFD       = 16'd13;
    localparam logic [15:0] TYPE_LONG8     = 16'd16;
    localparam logic [15:0] TYPE_SLONG8    = 16'd17;
    localparam logic [15:0] TYPE_IFD8      = 16'd18;

    typedef logic [MaxEntryBytes-1:0][7:0] tifd_bytes_t;
    typedef logic [WideFieldBytes-1:0][7:0] tifd_lanes_t;

    typedef struct packed {
        logic              kind;
        logic              big_endian;
        logic              bigt;
        logic              stitched;
        logic              osize8;
        logic              ptr_ok;
        tifd_bytes_t       bytes;
        logic [31:0]       index;
        logic [OfsW-1:0]   pos_ofs;
        logic [OfsW-1:0]   loc_ofs;
    } tifd_snap_t;

    typedef struct packed {
        logic        kind;
        logic [15:0] tag_code;
        logic [15:0] data_type;
        logic [63:0] value_count;
        logic [63:0] value_location;
        logic        inline_flag;
        logic [63:0] inline_value;
        logic [3:0]  inline_length;
        logic [63:0] entry_file_position;
        logic [31:0] entry_index;
    } tifd_result_t;

    // Assembles a 4- or 8-byte field in the configured byte order.
    function automatic logic [63:0] read_field(tifd_lanes_t lanes, logic wide, logic be);
        logic [63:0] v;
        v = '0;
        for (int k = 0; k < WideFieldBytes; k++) begin
            if (wide) begin
                v[8*k +: 8] = be ? lanes[3'(WideFieldBytes - 1 - k)] : lanes[3'(k)];
            end
            else if (k < NarrowFieldBytes) begin
                v[8*k +: 8] = be ? lanes[3'(NarrowFieldBytes - 1 - k)] : lanes[3'(k)];
            end
        end
        return v;
    endfunction

    // Returns the shift that divides the inline capacity by the type size.
    // The valid flag is low for types of unknown size.
    function automatic logic [2:0] type_shift(logic [15:0] dtype);
        logic [2:0] r;
        case (dtype)
            TYPE_BYTE, TYPE_ASCII, TYPE_SBYTE, TYPE_UNDEFINED:     r = 3'b100;
            TYPE_SHORT, TYPE_SSHORT:                               r = 3'b101;
            TYPE_LONG, TYPE_SLONG, TYPE_FLOAT, TYPE_IFD:           r = 3'b110;
            TYPE_RATIONAL, TYPE_SRATIONAL, TYPE_DOUBLE,
            TYPE_LONG8, TYPE_SLONG8, TYPE_IFD8:                    r = 3'b111;
            default:                                               r = 3'b000;
        endcase
        return r;
    endfunction

endpackage

// ===== rtl/tiff_ifd_entry_parser_core.sv =====
// Top level of the directory entry parser: byte collection, staging and result register.
//
// Channel  Handshake                  Payload
// item     item_valid / item_ready    region, byte_value, last_in_region
// result   result_valid / result_ready kind, tag_code ... entry_index
// cfg      cfg_valid / cfg_ready      cfg_index, cfg_data
//
// One byte is taken per cycle while item_ready is high; each byte updates the collection
// registers, and a byte that completes an entry or pointer also moves it into a staging register,
// from which it is decoded into the result register once that register is empty or its result is taken.
// item_ready drops only while both the staging and the result register are full.
// Reset clears the configuration and the stream state; cfg_ready is always high.
`include "tiff_ifd_entry_parser_core_defines.svh"

module tiff_ifd_entry_parser_core
    import tifd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [3:0]  cfg_index,
    input  logic [63:0] cfg_data,

    input  logic        item_valid,
    output logic        item_ready,
    input  logic        region,
    input  logic [7:0]  byte_value,
    input  logic        last_in_region,

    output logic        result_valid,
    input  logic        result_ready,
    output logic        kind,
    output logic [15:0] tag_code,
    output logic [15:0] data_type,
    output logic [63:0] value_count,
    output logic [63:0] value_location,
    output logic        inline_flag,
    output logic [63:0] inline_value,
    output logic [3:0]  inline_length,
    output logic [63:0] entry_file_position,
    output logic [31:0] entry_index
);

    logic [1:0]      mode_reg;
    logic            be_reg;
    logic [31:0]     tag_count_reg;
    logic [63:0]     offset_reg;

    tifd_bytes_t     entry_reg;
    tifd_bytes_t     entry_next;
    tifd_lanes_t     ptr_reg;
    tifd_lanes_t     ptr_next;
    logic [4:0]      bp_reg;
    logic [4:0]      bp_next;
    logic [31:0]     done_reg;
    logic [31:0]     done_next;
    logic [3:0]      plen_reg;
    logic [3:0]      plen_next;
    logic [OfsW-1:0] acc12_reg;
    logic [OfsW-1:0] acc12_next;
    logic [OfsW-1:0] acc20_reg;
    logic [OfsW-1:0] acc20_next;

    tifd_snap_t      snap_reg;
    tifd_snap_t      snap_next;
    logic            snap_valid_reg;
    logic            snap_valid_next;
    tifd_result_t    out_reg;
    tifd_result_t    decoded;
    logic            out_valid_reg;

    logic            accept;
    logic            out_load;
    logic            produce;
    logic            bigt;
    logic            stitched;
    logic            osize8;
    logic [4:0]      esize;
    logic [3:0]      osize;
    logic [4:0]      bp_inc;
    logic [3:0]      plen_inc;
    logic [OfsW-1:0] stride_acc;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= MODE_CLASSIC;
            be_reg        <= 1'b0;
            tag_count_reg <= '0;
            offset_reg    <= '0;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_FORMAT_MODE:       mode_reg      <= cfg_data[1:0];
                REG_BIG_ENDIAN:        be_reg        <= cfg_data[0];
                REG_TAG_COUNT:         tag_count_reg <= cfg_data[31:0];
                REG_TABLE_FILE_OFFSET: offset_reg    <= cfg_data;
                default:               ;
            endcase
        end
    end

    assign bigt     = (mode_reg == MODE_BIGTIFF);
    assign stitched = (mode_reg == MODE_STITCHED);
    assign osize8   = (mode_reg != MODE_CLASSIC);
    assign esize    = bigt ? 5'(BigEntryBytes)
                    : (stitched ? 5'(StitchedEntryBytes) : 5'(ClassicEntryBytes));
    assign osize    = osize8 ? 4'(WideFieldBytes) : 4'(NarrowFieldBytes);

    assign out_load   = snap_valid_reg && (!out_valid_reg || result_ready);
    assign item_ready = !snap_valid_reg || out_load;
    assign accept     = item_valid && item_ready;

    always_comb
    begin
        entry_next = entry_reg;
        ptr_next   = ptr_reg;
        bp_next    = bp_reg;
        done_next  = done_reg;
        plen_next  = plen_reg;
        acc12_next = acc12_reg;
        acc20_next = acc20_reg;
        produce    = 1'b0;
        bp_inc     = bp_reg;
        plen_inc   = plen_reg;
        stride_acc = bigt ? acc20_reg : acc12_reg;

        snap_next            = snap_reg;
        snap_next.big_endian = be_reg;
        snap_next.bigt       = bigt;
        snap_next.stitched   = stitched;
        snap_next.osize8     = osize8;
        snap_next.index      = done_reg;
        snap_next.pos_ofs    = stride_acc;
        snap_next.loc_ofs    = stride_acc + (bigt ? OfsW'(BigFieldOffset)
                                                  : OfsW'(ClassicFieldOffset));

        if (accept)
        begin
            if (region)
            begin
                if (plen_reg < osize)
                begin
                    ptr_next[plen_reg[2:0]] = byte_value;
                    plen_inc = plen_reg + 4'd1;
                end
                plen_next = plen_inc;
                if (last_in_region)
                begin
                    produce          = 1'b1;
                    snap_next.kind   = 1'b1;
                    snap_next.ptr_ok = (plen_inc >= osize);
                    snap_next.bytes  = '0;
                    snap_next.bytes[7:0] = ptr_next;
                    bp_next    = '0;
                    done_next  = '0;
                    plen_next  = '0;
                    acc12_next = '0;
                    acc20_next = '0;
                end
            end
            else
            begin
                if (bp_reg < 5'(MaxEntryBytes))
                begin
                    entry_next[bp_reg] = byte_value;
                    bp_inc = bp_reg + 5'd1;
                end
                if (bp_inc < esize)
                begin
                    bp_next = last_in_region ? 5'd0 : bp_inc;
                end
                else
                begin
                    bp_next = '0;
                    if (done_reg < tag_count_reg)
                    begin
                        produce          = 1'b1;
                        snap_next.kind   = 1'b0;
                        snap_next.ptr_ok = 1'b0;
                        snap_next.bytes  = entry_next;
                        done_next  = done_reg + 32'd1;
                        acc12_next = acc12_reg + OfsW'(ClassicEntryBytes);
                        acc20_next = acc20_reg + OfsW'(BigEntryBytes);
                    end
                end
            end
        end

        if (produce)
        begin
            snap_valid_next = 1'b1;
        end
        else
        begin
            snap_valid_next = snap_valid_reg && !out_load;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bp_reg         <= '0;
            done_reg       <= '0;
            plen_reg       <= '0;
            acc12_reg      <= '0;
            acc20_reg      <= '0;
            snap_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            bp_reg         <= bp_next;
            done_reg       <= done_next;
            plen_reg       <= plen_next;
            acc12_reg      <= acc12_next;
            acc20_reg      <= acc20_next;
            snap_valid_reg <= snap_valid_next;
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
        ptr_reg   <= ptr_next;
        if (produce)
        begin
            snap_reg <= snap_next;
        end
        if (out_load)
        begin
            out_reg <= decoded;
        end
    end

    tifd_decode u_decode
    (
        .snap              (snap_reg),
        .table_file_offset (offset_reg),
        .res               (decoded)
    );

    assign result_valid        = out_valid_reg;
    assign kind                = out_reg.kind;
    assign tag_code            = out_reg.tag_code;
    assign data_type           = out_reg.data_type;
    assign value_count         = out_reg.value_count;
    assign value_location      = out_reg.value_location;
    assign inline_flag         = out_reg.inline_flag;
    assign inline_value        = out_reg.inline_value;
    assign inline_length       = out_reg.inline_length;
    assign entry_file_position = out_reg.entry_file_position;
    assign entry_index         = out_reg.entry_index;

    `TIFD_ASSERT_ALWAYS(a_bp_range, bp_reg <= 5'(MaxEntryBytes), "Entry byte position overflow.")
    `TIFD_ASSERT_ALWAYS(a_plen_range, plen_reg <= 4'(WideFieldBytes), "Pointer length overflow.")
    `TIFD_ASSERT(a_stall_cause, !item_ready |-> (snap_valid_reg && result_valid && !result_ready), "Input stalled without a full pipeline.")
    `TIFD_ASSERT(a_ptr_clears, (accept && region && last_in_region) |=> (done_reg == 32'd0 && bp_reg == 5'd0 && plen_reg == 4'd0), "Pointer end did not clear the stream state.")
    `TIFD_ASSERT(a_acc_track, acc12_reg == OfsW'(done_reg) * OfsW'(ClassicEntryBytes), "Position accumulator out of step with entry count.")

endmodule

// ===== rtl/tifd_decode.sv =====
// Field extraction and inline test for one collected entry or pointer.
module tifd_decode
    import tifd_pkg::*;
(
    input  tifd_snap_t   snap,
    input  logic [63:0]  table_file_offset,
    output tifd_result_t res
);

    tifd_lanes_t count_lanes;
    tifd_lanes_t field_lanes;
    tifd_lanes_t ptr_lanes;
    logic        flen8;
    logic [63:0] count;
    logic [63:0] field_value;
    logic [63:0] ptr_value;
    logic [63:0] pos;
    logic [63:0] inline_loc;
    logic [2:0]  tshift;
    logic [3:0]  cap;
    logic [3:0]  limit;
    logic        inl;

    assign count_lanes = snap.bytes[11:4];
    assign field_lanes = snap.bytes[19:12];
    assign ptr_lanes   = snap.bytes[7:0];
    assign flen8       = snap.bigt || snap.stitched;

    tifd_lanes_t fl;
    assign fl = snap.bigt ? field_lanes : snap.bytes[15:8];

    assign count       = read_field(count_lanes, snap.bigt, snap.big_endian);
    assign field_value = read_field(fl, flen8, snap.big_endian);
    assign ptr_value   = read_field(ptr_lanes, snap.osize8, snap.big_endian);

    assign pos        = table_file_offset + 64'(snap.pos_ofs);
    assign inline_loc = table_file_offset + 64'(snap.loc_ofs);

    assign tshift = type_shift(snap.bigt ? 16'h0 : 16'h0);

    logic [15:0] code;
    logic [15:0] dtype;
    logic [2:0]  ts;

    assign code  = snap.big_endian ? {snap.bytes[0], snap.bytes[1]}
                                   : {snap.bytes[1], snap.bytes[0]};
    assign dtype = snap.big_endian ? {snap.bytes[2], snap.bytes[3]}
                                   : {snap.bytes[3], snap.bytes[2]};
    assign ts    = type_shift(dtype) | tshift;
    assign cap   = snap.bigt ? 4'(WideFieldBytes) : 4'(NarrowFieldBytes);
    assign limit = cap >> ts[1:0];
    assign inl   = !ts[2] || (count <= {60'b0, limit});

    always_comb
    begin
        res = '0;
        res.kind = snap.kind;
        if (snap.kind)
        begin
            res.value_location = snap.ptr_ok ? ptr_value : 64'b0;
            res.inline_length  = snap.osize8 ? 4'(WideFieldBytes) : 4'(NarrowFieldBytes);
        end
        else
        begin
            res.tag_code            = code;
            res.data_type           = dtype;
            res.value_count         = count;
            res.value_location      = inl ? inline_loc : field_value;
            res.inline_flag         = inl;
            res.inline_value        = flen8 ? 64'(fl) : {32'b0, fl[3:0]};
            res.inline_length       = flen8 ? 4'(WideFieldBytes) : 4'(NarrowFieldBytes);
            res.entry_file_position = pos;
            res.entry_index         = snap.index;
        end
    end

endmodule
